@@ rtl/ccyu_pkg.sv @@
// Shared types and constants for the camera capture YUYV unpack unit.
package ccyu_pkg;

  localparam int unsigned MAX_LINES      = 1024;
  localparam int unsigned MAX_LINE_BYTES = 2048;

  localparam int unsigned LINES_W = 11;
  localparam int unsigned BYTES_W = 12;
  localparam int unsigned ROW_W   = 10;
  localparam int unsigned COL_W   = 10;
  localparam int unsigned BCNT_W  = 11;
  localparam int unsigned PIX_W   = 8;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned OUT_TUSER_W = 2;
  localparam int unsigned CFG_DATA_W  = 12;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [LINES_W-1:0] LINES_RST = LINES_W'(480);
  localparam logic [BYTES_W-1:0] BYTES_RST = BYTES_W'(1280);
  localparam logic [LINES_W-1:0] LINES_MAX = LINES_W'(MAX_LINES);
  localparam logic [BYTES_W-1:0] BYTES_MAX = BYTES_W'(MAX_LINE_BYTES & ~3);
  localparam logic [BYTES_W-1:0] BYTES_MIN = BYTES_W'(4);

  typedef enum logic [2:0] {
    PH_VS_HIGH,
    PH_VS_LOW,
    PH_LINE_START,
    PH_PCLK_HIGH,
    PH_PCLK_LOW,
    PH_HREF_END
  } phase_e;

  typedef enum logic [1:0] {
    EV_PIXEL,
    EV_FRAME_DONE,
    EV_VSYNC_ERR,
    EV_HREF_ERR
  } event_e;

  typedef enum logic {
    REG_LINES_PER_FRAME = 1'b0,
    REG_BYTES_PER_LINE  = 1'b1
  } reg_idx_e;

  // Port sample, vsync in the lowest bit.
  typedef struct packed {
    logic [PIX_W-1:0] port_byte;
    logic             pclk;
    logic             href;
    logic             vsync;
  } in_t;

  typedef struct packed {
    logic             last;
    logic [PIX_W-1:0] chroma_red;
    logic [PIX_W-1:0] chroma_blue;
    logic [PIX_W-1:0] luma;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    event_e           kind;
  } res_t;

  // Results of one processed sample: count is 0, 1 or 2.
  typedef struct packed {
    logic [1:0] count;
    res_t       res0;
    res_t       res1;
  } step_t;

endpackage

@@ rtl/ccyu_core.sv @@
// Capture state machine: sync tracking, byte latch and YUYV pair assembly.
module ccyu_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_en_i,
  input  ccyu_pkg::in_t                 item_i,
  input  logic [ccyu_pkg::LINES_W-1:0]  lines_cfg_i,
  input  logic [ccyu_pkg::BYTES_W-1:0]  bytes_cfg_i,
  output ccyu_pkg::step_t               step_o
);
  import ccyu_pkg::*;

  phase_e              phase_q, phase_d;
  logic [ROW_W-1:0]    line_q, line_d;
  logic [BCNT_W-1:0]   byte_q, byte_d;
  logic [PIX_W-1:0]    latch_q, latch_d;
  logic [PIX_W-1:0]    group_q [3];
  logic                group_we;
  logic [1:0]          group_idx;

  logic [LINES_W-1:0]  lines_eff, lines_m1, line_inc;
  logic [BYTES_W-1:0]  bytes_eff, bytes_rnd, byte_inc;
  res_t                blank;
  step_t               step;

  // clamp the programmed geometry
  always_comb begin
    lines_eff = lines_cfg_i;
    if (lines_cfg_i == '0) begin
      lines_eff = LINES_W'(1);
    end else if (lines_cfg_i > LINES_MAX) begin
      lines_eff = LINES_MAX;
    end
    bytes_rnd = {bytes_cfg_i[BYTES_W-1:2], 2'b00};
    bytes_eff = bytes_rnd;
    if (bytes_rnd < BYTES_MIN) begin
      bytes_eff = BYTES_MIN;
    end else if (bytes_rnd > BYTES_MAX) begin
      bytes_eff = BYTES_MAX;
    end
  end

  assign lines_m1 = lines_eff - LINES_W'(1);
  assign line_inc = {1'b0, line_q} + LINES_W'(1);
  assign byte_inc = {1'b0, byte_q} + BYTES_W'(1);

  always_comb begin
    blank      = '0;
    blank.last = 1'b1;
    step       = '0;
    phase_d    = phase_q;
    line_d     = line_q;
    byte_d     = byte_q;
    latch_d    = latch_q;
    group_we   = 1'b0;
    group_idx  = byte_q[1:0];

    unique case (phase_q)
      PH_VS_LOW: begin
        if (!item_i.vsync) begin
          phase_d = PH_LINE_START;
          line_d  = '0;
          byte_d  = '0;
        end
      end
      PH_LINE_START: begin
        if (item_i.vsync) begin
          step.count     = 2'd1;
          step.res0      = blank;
          step.res0.kind = EV_VSYNC_ERR;
          step.res0.row  = line_q;
          phase_d        = PH_VS_HIGH;
          line_d         = '0;
          byte_d         = '0;
        end else if (item_i.href) begin
          byte_d  = '0;
          phase_d = PH_PCLK_HIGH;
        end
      end
      PH_PCLK_HIGH: begin
        if (item_i.pclk) begin
          latch_d = item_i.port_byte;
          phase_d = PH_PCLK_LOW;
        end
      end
      PH_PCLK_LOW: begin
        if (!item_i.href && ({1'b0, byte_q} != bytes_eff - BYTES_W'(1))) begin
          step.count       = 2'd1;
          step.res0        = blank;
          step.res0.kind   = EV_HREF_ERR;
          step.res0.row    = line_q;
          step.res0.column = byte_q[BCNT_W-1:1];
          phase_d          = PH_VS_HIGH;
          line_d           = '0;
          byte_d           = '0;
        end else if (!item_i.pclk) begin
          if (byte_q[1:0] != 2'd3) begin
            group_we = 1'b1;
          end else begin
            // Y0 U Y1 V complete: two pixels sharing U and V
            step.count            = 2'd2;
            step.res0.kind        = EV_PIXEL;
            step.res0.row         = line_q;
            step.res0.column      = {byte_q[BCNT_W-1:2], 1'b0};
            step.res0.luma        = group_q[0];
            step.res0.chroma_blue = group_q[1];
            step.res0.chroma_red  = latch_q;
            step.res0.last        = 1'b0;
            step.res1             = step.res0;
            step.res1.column      = {byte_q[BCNT_W-1:2], 1'b1};
            step.res1.luma        = group_q[2];
            step.res1.last        = 1'b1;
          end
          byte_d  = byte_inc[BCNT_W-1:0];
          phase_d = (byte_inc >= bytes_eff) ? PH_HREF_END : PH_PCLK_HIGH;
        end
      end
      PH_HREF_END: begin
        if (!item_i.href) begin
          byte_d = '0;
          if (line_inc >= lines_eff) begin
            step.count     = 2'd1;
            step.res0      = blank;
            step.res0.kind = EV_FRAME_DONE;
            step.res0.row  = lines_m1[ROW_W-1:0];
            phase_d        = PH_VS_HIGH;
            line_d         = '0;
          end else begin
            line_d  = line_inc[ROW_W-1:0];
            phase_d = PH_LINE_START;
          end
        end
      end
      default: begin
        // waiting for vsync high; unused codes behave the same
        phase_d = item_i.vsync ? PH_VS_LOW : PH_VS_HIGH;
      end
    endcase

    if (!step_en_i) begin
      step.count = 2'd0;
    end
  end

  assign step_o = step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_VS_HIGH;
      line_q  <= '0;
      byte_q  <= '0;
      latch_q <= '0;
    end else if (step_en_i) begin
      phase_q <= phase_d;
      line_q  <= line_d;
      byte_q  <= byte_d;
      latch_q <= latch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en_i && group_we) begin
      group_q[group_idx] <= latch_q;
    end
  end

`ifndef ASSERT_OFF
  a_pair_only_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step.count == 2'd2 |-> phase_q == PH_PCLK_LOW && byte_q[1:0] == 2'd3)
    else $error("pixel pair outside a byte commit");
  a_last_marks_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step.count == 2'd1 |-> step.res0.last) and
    (step.count == 2'd2 |-> !step.res0.last && step.res1.last))
    else $error("last flag not on final result of a sample");
`endif

endmodule

@@ rtl/ccyu_out_fifo.sv @@
// Four-entry result queue, takes up to two results per cycle, drains one.
module ccyu_out_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ccyu_pkg::step_t push_i,
  output logic            room_o,
  output logic            valid_o,
  input  logic            ready_i,
  output ccyu_pkg::res_t  head_o
);
  import ccyu_pkg::*;

  res_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr1;
  logic [FIFO_CW-1:0] count_q;
  logic               pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign room_o  = (count_q <= FIFO_CW'(FIFO_DEPTH - 2));
  assign wr_ptr1 = wr_ptr_q + FIFO_AW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FIFO_AW'(push_i.count);
      rd_ptr_q <= rd_ptr_q + FIFO_AW'(pop);
      count_q  <= count_q + FIFO_CW'(push_i.count) - FIFO_CW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr1] <= push_i.res1;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.count != 2'd0 |-> room_o)
    else $error("result queue written without room");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue count out of range");
`endif

endmodule

@@ rtl/camera_capture_yuyv_unpack_unit.sv @@
// Top level: DVP camera capture with YUYV 4:2:2 unpacking to pixel events.
// Samples are registered on input and results in the queue. Throughput: one
// sample word per cycle while the queue has room; a sample yields at most two
// result words. A pixel pair needs at least eight samples, so the 4-entry result
// queue keeps pace. Reset (rst_ni low, async): capture waits for vsync high,
// counters cleared, queue empty, registers back to 480 lines of 1280 bytes.
module camera_capture_yuyv_unpack_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // sample stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: vsync, href, pclk, port_byte[7:0], 5 zero bits
  input  logic [ccyu_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata: row[9:0], column[9:0], luma, chroma_blue, chroma_red, 4 zero bits
  output logic [ccyu_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // tuser: event_kind[1:0] (pixel, frame done, vsync error, href error)
  output logic [ccyu_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
  output logic                                 m_axis_tlast,
  // register writes
  input  logic                                 cfg_we_i,
  input  ccyu_pkg::reg_idx_e                   cfg_addr_i,
  input  logic [ccyu_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import ccyu_pkg::*;

  logic [LINES_W-1:0] lines_cfg_q;
  logic [BYTES_W-1:0] bytes_cfg_q;

  logic  in_vld_q;
  in_t   in_q;
  logic  room;
  logic  take;
  step_t step;
  res_t  head;

  // geometry registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lines_cfg_q <= LINES_RST;
      bytes_cfg_q <= BYTES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_LINES_PER_FRAME: lines_cfg_q <= cfg_wdata_i[LINES_W-1:0];
        REG_BYTES_PER_LINE:  bytes_cfg_q <= cfg_wdata_i[BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  // input register: a sample is processed once the queue has room for two results
  assign take          = in_vld_q && room;
  assign s_axis_tready = !in_vld_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q <= in_t'(s_axis_tdata[$bits(in_t)-1:0]);
    end
  end

  ccyu_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (take),
    .item_i      (in_q),
    .lines_cfg_i (lines_cfg_q),
    .bytes_cfg_i (bytes_cfg_q),
    .step_o      (step)
  );

  ccyu_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .head_o  (head)
  );

  assign m_axis_tdata = {4'b0000, head.chroma_red, head.chroma_blue, head.luma,
                         head.column, head.row};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

endmodule

@@ bench/tb_camera_capture_yuyv_unpack_unit.sv @@
// Self-checking bench for the camera capture YUYV unpack unit.
`timescale 1ns / 100ps

module tb_camera_capture_yuyv_unpack_unit;
  import ccyu_pkg::*;

  // allowance for result words trailing their sample, used by wait_idle
  localparam int unsigned RESULT_LATENCY = 2;
  localparam int unsigned CYCLE_LIMIT    = 500000;
  localparam int unsigned RANDOM_FORMATS = 8;
  localparam int unsigned WORDS_PER_FMT  = 120;

  // how a generated line is broken
  localparam int unsigned FAULT_NONE  = 0;
  localparam int unsigned FAULT_VSYNC = 1; // vsync high while waiting for href
  localparam int unsigned FAULT_HREF  = 2; // href drops after a byte is latched

  // one expected result word
  typedef struct packed {
    event_e           kind;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] chroma_blue;
    logic [PIX_W-1:0] chroma_red;
    logic             last;
  } pix_event_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_we_i      = 1'b0;
  reg_idx_e               cfg_addr_i    = REG_LINES_PER_FRAME;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i   = '0;

  // stimulus and scoreboard
  logic [IN_TDATA_W-1:0] sample_q [$];
  pix_event_t            pending_events [$];
  int unsigned           words_queued  = 0;
  int unsigned           words_taken   = 0;
  int unsigned           err_cnt       = 0;
  int unsigned           cycle_cnt     = 0;
  int unsigned           formats_run   = 0;
  int unsigned           kind_seen [4] = '{0, 0, 0, 0};
  bit                    idle_en       = 1'b1;
  int unsigned           feed_gap      = 0;
  int unsigned           drain_stall   = 0;

  // capture predictor: configuration copy and state
  logic [LINES_W-1:0] lines_cfg = LINES_RST;
  logic [BYTES_W-1:0] bytes_cfg = BYTES_RST;
  phase_e             cap_phase = PH_VS_HIGH;
  logic [31:0]        line_cnt  = '0;
  logic [31:0]        byte_cnt  = '0;
  logic [PIX_W-1:0]   held_byte = '0;
  logic [PIX_W-1:0]   yuv_grp [3];

  camera_capture_yuyv_unpack_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Effective frame geometry: lines clamp to 1..MAX_LINES, bytes round down to
  // a multiple of four and clamp to 4..MAX_LINE_BYTES.
  // ---------------------------------------------------------------------------
  function automatic int unsigned eff_lines(input logic [LINES_W-1:0] raw);
    int unsigned n;
    n = raw;
    if (n == 0) n = 1;
    if (n > MAX_LINES) n = MAX_LINES;
    return n;
  endfunction

  function automatic int unsigned eff_bytes(input logic [BYTES_W-1:0] raw);
    int unsigned n;
    n = raw & ~32'd3;
    if (n < 4) n = 4;
    if (n > (MAX_LINE_BYTES & ~3)) n = MAX_LINE_BYTES & ~3;
    return n;
  endfunction

  task automatic post_event(input event_e kind, input logic [31:0] row,
                            input logic [31:0] col, input logic [PIX_W-1:0] y,
                            input logic [PIX_W-1:0] u, input logic [PIX_W-1:0] v,
                            input logic last);
    pix_event_t ev;
    ev.kind        = kind;
    ev.row         = row[ROW_W-1:0];
    ev.column      = col[COL_W-1:0];
    ev.luma        = y;
    ev.chroma_blue = u;
    ev.chroma_red  = v;
    ev.last        = last;
    pending_events.push_back(ev);
  endtask

  task automatic restart_capture();
    cap_phase = PH_VS_HIGH;
    line_cnt  = '0;
    byte_cnt  = '0;
  endtask

  // Advance the capture predictor by one sample word; queue what it yields.
  task automatic capture_step(input logic [IN_TDATA_W-1:0] word);
    in_t         smp;
    int unsigned nbytes;
    int unsigned nlines;
    logic [31:0] col;
    smp    = word[$bits(in_t)-1:0];
    nbytes = eff_bytes(bytes_cfg);
    nlines = eff_lines(lines_cfg);
    case (cap_phase)
      PH_VS_LOW: begin
        if (!smp.vsync) begin
          cap_phase = PH_LINE_START;
          line_cnt  = '0;
          byte_cnt  = '0;
        end
      end
      PH_LINE_START: begin
        if (smp.vsync) begin
          post_event(EV_VSYNC_ERR, line_cnt, 0, 8'h00, 8'h00, 8'h00, 1'b1);
          restart_capture();
        end else if (smp.href) begin
          byte_cnt  = '0;
          cap_phase = PH_PCLK_HIGH;
        end
      end
      PH_PCLK_HIGH: begin
        if (smp.pclk) begin
          held_byte = smp.port_byte;
          cap_phase = PH_PCLK_LOW;
        end
      end
      PH_PCLK_LOW: begin
        // href may only drop early on the final byte of the line
        if (!smp.href && byte_cnt != nbytes - 1) begin
          post_event(EV_HREF_ERR, line_cnt, byte_cnt >> 1, 8'h00, 8'h00, 8'h00, 1'b1);
          restart_capture();
        end else if (!smp.pclk) begin
          if (byte_cnt[1:0] != 2'd3) begin
            yuv_grp[byte_cnt[1:0]] = held_byte;
          end else begin
            // Y0 U Y1 V: two pixels sharing the chroma pair
            col = (byte_cnt >> 2) << 1;
            post_event(EV_PIXEL, line_cnt, col, yuv_grp[0], yuv_grp[1], held_byte, 1'b0);
            post_event(EV_PIXEL, line_cnt, col + 1, yuv_grp[2], yuv_grp[1], held_byte,
                       1'b1);
          end
          byte_cnt++;
          cap_phase = (byte_cnt >= nbytes) ? PH_HREF_END : PH_PCLK_HIGH;
        end
      end
      PH_HREF_END: begin
        if (!smp.href) begin
          line_cnt++;
          byte_cnt = '0;
          if (line_cnt >= nlines) begin
            post_event(EV_FRAME_DONE, nlines - 1, 0, 8'h00, 8'h00, 8'h00, 1'b1);
            restart_capture();
          end else begin
            cap_phase = PH_LINE_START;
          end
        end
      end
      default: cap_phase = smp.vsync ? PH_VS_LOW : PH_VS_HIGH;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Sample word driver: drives words from sample_q, predicts every accepted word.
  // Gaps in tvalid come at random while idle_en is set.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        capture_step(s_axis_tdata);
        words_taken++;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the word until taken
      end else if (feed_gap > 0) begin
        feed_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (idle_en && sample_q.size() != 0 && $urandom_range(0, 4) == 0) begin
        feed_gap = $urandom_range(0, 2);
        s_axis_tvalid <= 1'b0;
      end else if (sample_q.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample_q.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result monitor: compares each accepted word with the oldest prediction.
  // tdata: row, column, luma, chroma_blue, chroma_red from bit 0 up.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    pix_event_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        kind_seen[m_axis_tuser]++;
        if (pending_events.size() == 0) begin
          $error("result word with nothing expected: kind %0d tdata %h",
                 m_axis_tuser, m_axis_tdata);
          err_cnt++;
        end else begin
          want = pending_events.pop_front();
          check_field("event_kind", want.kind, m_axis_tuser);
          check_field("row", want.row, m_axis_tdata[9:0]);
          check_field("column", want.column, m_axis_tdata[19:10]);
          check_field("luma", want.luma, m_axis_tdata[27:20]);
          check_field("chroma_blue", want.chroma_blue, m_axis_tdata[35:28]);
          check_field("chroma_red", want.chroma_red, m_axis_tdata[43:36]);
          check_field("last", want.last, m_axis_tlast);
        end
      end
      if (drain_stall > 0) begin
        drain_stall--;
        m_axis_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        drain_stall = $urandom_range(0, 2);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("camera_capture_yuyv_unpack_unit regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_sample(input logic vs, input logic hr, input logic pc,
                             input logic [PIX_W-1:0] b);
    in_t smp;
    smp.vsync     = vs;
    smp.href      = hr;
    smp.pclk      = pc;
    smp.port_byte = b;
    sample_q.push_back(IN_TDATA_W'(smp));
    words_queued++;
  endtask

  task automatic queue_noise(input int unsigned n);
    repeat (n) push_sample($urandom_range(0, 1), $urandom_range(0, 1),
                           $urandom_range(0, 1), $urandom_range(0, 255));
  endtask

  task automatic queue_vsync_pulse(input bit tight);
    repeat (tight ? 1 : $urandom_range(1, 3))
      push_sample(1'b1, 1'b0, $urandom_range(0, 1), $urandom_range(0, 255));
  endtask

  // Blanking, href rise, then nb bytes as pclk high/low pairs. The last byte
  // may carry href low (allowed). A fault cuts the line short.
  task automatic queue_line(input int unsigned nb, input bit tight,
                            input int unsigned fault);
    int unsigned      drop_at;
    logic [PIX_W-1:0] data;
    logic             lastb;
    drop_at = (fault == FAULT_HREF) ? $urandom_range(0, (nb > 8) ? 6 : nb - 2) : nb;
    repeat (tight ? 1 : $urandom_range(1, 3))
      push_sample(1'b0, 1'b0, $urandom_range(0, 1), $urandom_range(0, 255));
    if (fault == FAULT_VSYNC) begin
      push_sample(1'b1, 1'b0, $urandom_range(0, 1), $urandom_range(0, 255));
      return;
    end
    push_sample(1'b0, 1'b1, 1'b0, $urandom_range(0, 255));
    for (int unsigned k = 0; k < nb; k++) begin
      data  = $urandom_range(0, 255);
      lastb = (k == nb - 1);
      repeat (tight ? 1 : $urandom_range(1, 2))
        push_sample(1'b0, lastb ? $urandom_range(0, 1) : 1'b1, 1'b1, data);
      if (k == drop_at) begin
        push_sample(1'b0, 1'b0, 1'b0, $urandom_range(0, 255));
        return;
      end
      repeat (tight ? 1 : $urandom_range(1, 2))
        push_sample(1'b0, lastb ? $urandom_range(0, 1) : 1'b1, 1'b0,
                    $urandom_range(0, 255));
    end
  endtask

  // Whole frame at the current geometry; faults stop it early.
  task automatic queue_frame(input bit tight, input bit faults);
    int unsigned fault;
    queue_vsync_pulse(tight);
    for (int unsigned l = 0; l < eff_lines(lines_cfg); l++) begin
      fault = (faults && $urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : FAULT_NONE;
      queue_line(eff_bytes(bytes_cfg), tight, fault);
      if (fault != FAULT_NONE) return;
    end
    push_sample(1'b0, 1'b0, $urandom_range(0, 1), $urandom_range(0, 255));
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    if (idx == REG_LINES_PER_FRAME) lines_cfg = val[LINES_W-1:0];
    else bytes_cfg = val[BYTES_W-1:0];
  endtask

  task automatic set_frame_format(input logic [CFG_DATA_W-1:0] lines_raw,
                                  input logic [CFG_DATA_W-1:0] bytes_raw);
    write_reg(REG_LINES_PER_FRAME, lines_raw);
    write_reg(REG_BYTES_PER_LINE, bytes_raw);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    formats_run++;
  endtask

  // Block is idle once every word is taken, every result seen, and words that
  // yield nothing have left the pipeline.
  task automatic wait_idle();
    while (words_taken != words_queued || pending_events.size() != 0)
      @(posedge clk_i);
    repeat (2 * RESULT_LATENCY) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned mark;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset geometry (480 x 1280): vsync error at line start, then an href
    // drop right after the first latch.
    push_sample(1'b1, 1'b0, 1'b1, 8'hFF);
    push_sample(1'b0, 1'b0, 1'b0, 8'h00);
    push_sample(1'b1, 1'b1, 1'b1, 8'hFF);
    push_sample(1'b1, 1'b0, 1'b0, 8'h00);
    push_sample(1'b0, 1'b0, 1'b0, 8'h00);
    push_sample(1'b0, 1'b1, 1'b0, 8'h00);
    push_sample(1'b0, 1'b1, 1'b1, 8'hFF);
    push_sample(1'b0, 1'b0, 1'b1, 8'h00);
    wait_idle();

    // Smallest frame: one line, one pixel pair, href low over the last byte.
    set_frame_format(1, 4);
    push_sample(1'b1, 1'b0, 1'b0, 8'h00);
    push_sample(1'b0, 1'b0, 1'b0, 8'h00);
    push_sample(1'b0, 1'b1, 1'b0, 8'h00);
    push_sample(1'b0, 1'b1, 1'b1, 8'hFF);
    push_sample(1'b0, 1'b1, 1'b0, 8'h00);
    push_sample(1'b0, 1'b1, 1'b1, 8'h00);
    push_sample(1'b0, 1'b1, 1'b0, 8'hFF);
    push_sample(1'b0, 1'b1, 1'b1, 8'hA5);
    push_sample(1'b0, 1'b1, 1'b0, 8'h5A);
    push_sample(1'b0, 1'b0, 1'b1, 8'h5A);
    push_sample(1'b0, 1'b0, 1'b0, 8'hA5);
    push_sample(1'b0, 1'b0, 1'b0, 8'h00);
    wait_idle();

    // Zero in both registers clamps to 1 line of 4 bytes.
    set_frame_format(0, 0);
    repeat (3) queue_frame(1'b0, 1'b0);
    wait_idle();

    // Oversize values clamp to 1024 x 2048; the first line breaks on an href
    // drop early on.
    set_frame_format(2047, 4095);
    queue_vsync_pulse(1'b1);
    queue_line(eff_bytes(bytes_cfg), 1'b0, FAULT_HREF);
    wait_idle();

    // Top line count with short lines; vsync at the fourth line start.
    set_frame_format(MAX_LINES, 3);
    queue_vsync_pulse(1'b0);
    repeat (3) queue_line(eff_bytes(bytes_cfg), 1'b0, FAULT_NONE);
    queue_line(eff_bytes(bytes_cfg), 1'b0, FAULT_VSYNC);
    wait_idle();

    // Random formats: mostly well-formed frames, some broken, some noise.
    // The final format runs with both sides streaming flat out.
    for (int unsigned f = 0; f < RANDOM_FORMATS; f++) begin
      if (f == RANDOM_FORMATS - 1) idle_en = 1'b0;
      set_frame_format($urandom_range(0, 4), $urandom_range(0, 20));
      mark = words_queued;
      while (words_queued - mark < WORDS_PER_FMT) begin
        if ($urandom_range(0, 7) == 0) queue_noise($urandom_range(4, 16));
        else queue_frame($urandom_range(0, 3) == 0, 1'b1);
      end
      wait_idle();
    end

    $display("%0d sample words over %0d frame formats", words_taken, formats_run);
    $display("results: %0d pixels, %0d frame ends, %0d vsync errors, %0d href errors",
             kind_seen[EV_PIXEL], kind_seen[EV_FRAME_DONE], kind_seen[EV_VSYNC_ERR],
             kind_seen[EV_HREF_ERR]);
    if (err_cnt == 0) begin
      $display("camera_capture_yuyv_unpack_unit regression: pass");
    end else begin
      $display("camera_capture_yuyv_unpack_unit regression: fail");
    end
    $finish;
  end

endmodule
